// ===== rtl/core/tsrr_pkg.sv =====
// Shared types and codes for the task slot round-robin dispatcher.
// No dependencies.
`timescale 1ns / 1ps

package tsrr_pkg;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_SWITCH  = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_IDLE = 2'd2;

  localparam logic [1:0] SLOT_UNUSED   = 2'd0;
  localparam logic [1:0] SLOT_READY    = 2'd1;
  localparam logic [1:0] SLOT_RUNNABLE = 2'd2;
  localparam logic [1:0] SLOT_RUNNING  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] target_slot;
    logic       preempt;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] chosen_slot;
    logic       first_run;
  } rsp_t;

endpackage

// ===== rtl/core/tsrr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tsrr_ram #(
  parameter int Width = 2,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/task_slot_round_robin_dispatcher_unit.sv =====
// Task slot round-robin dispatcher: top level.
// Depends on tsrr_pkg and tsrr_ram.
// Usage:
//   Request channel in_valid_i / in_stall_o / in_item_i carries one operation
//   item: allocate, release or switch. Response channel out_valid_o /
//   out_stall_i / out_item_o returns exactly one result item per request.
//   The slot table sits in a single RAM with a registered read port; a table
//   of valid flags makes never-written slots read as unused.
//   Timing: the block takes one item at a time. Release and unknown operations
//   go straight to the result stage. Allocate and switch scan the RAM at one
//   slot per cycle through the single read port; a switch with preemption
//   first does a read-modify-write of the preempted slot.
//   Reset clears all slots to unused at once (flags cleared), no sweep.
//   A stalled result stays in the output register; the next item may be
//   accepted meanwhile and waits before its result stage until it drains.
`timescale 1ns / 1ps

module task_slot_round_robin_dispatcher_unit #(
  parameter int SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tsrr_pkg::req_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tsrr_pkg::rsp_t out_item_o
);
  import tsrr_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TW = (IW > 6) ? IW : 6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE_RD, ST_PRE_CHK, ST_SCAN, ST_DONE
  } fsm_e;

  fsm_e            state_q, state_d;
  logic            is_alloc_q, is_alloc_d;
  logic [IW-1:0]   tgt_q, tgt_d;
  logic [IW-1:0]   rd_addr_q, rd_addr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            chk_pend_q, chk_pend_d;
  logic [IW-1:0]   chk_addr_q, chk_addr_d;
  logic [SLOTS-1:0] vld_q, vld_d;
  logic            rd_vld_q;
  rsp_t            res_q, res_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic            we;
  logic [IW-1:0]   waddr;
  logic [1:0]      wdata;
  logic [IW-1:0]   raddr;
  logic [1:0]      ram_rdata;
  logic [1:0]      sdata;
  logic            accept;
  logic            in_range;
  logic [IW-1:0]   in_idx;
  logic [TW-1:0]   tgt_w;
  logic [TW-1:0]   chk_w;
  logic            hit;

  tsrr_ram #(
    .Width (2),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_range = ({26'd0, in_item_i.target_slot} < 32'(SLOTS));
  assign tgt_w    = TW'(in_item_i.target_slot);
  assign in_idx   = tgt_w[IW-1:0];
  assign chk_w    = TW'(chk_addr_q);
  assign raddr    = (state_q == ST_PRE_RD) ? tgt_q : rd_addr_q;
  assign sdata    = rd_vld_q ? ram_rdata : SLOT_UNUSED;
  assign hit      = chk_pend_q && (is_alloc_q ? (sdata == SLOT_UNUSED)
                                              : (sdata == SLOT_READY ||
                                                 sdata == SLOT_RUNNABLE));

  always_comb begin
    state_d     = state_q;
    is_alloc_d  = is_alloc_q;
    tgt_d       = tgt_q;
    rd_addr_d   = rd_addr_q;
    cnt_d       = cnt_q;
    chk_pend_d  = 1'b0;
    chk_addr_d  = chk_addr_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = chk_addr_q;
    wdata       = SLOT_RUNNING;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d      = '0;
          cnt_d      = '0;
          rd_addr_d  = '0;
          tgt_d      = in_idx;
          is_alloc_d = (in_item_i.op == OP_ALLOC);
          case (in_item_i.op)
            OP_ALLOC: state_d = ST_SCAN;
            OP_RELEASE: begin
              we      = in_range;
              waddr   = in_idx;
              wdata   = SLOT_UNUSED;
              state_d = ST_DONE;
            end
            OP_SWITCH: begin
              if (in_item_i.preempt && in_range) begin
                state_d = ST_PRE_RD;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_PRE_RD: begin
        state_d   = ST_PRE_CHK;
        rd_addr_d = (tgt_q == IW'(SLOTS - 1)) ? '0 : tgt_q + 1'b1;
      end
      ST_PRE_CHK: begin
        we      = (sdata == SLOT_RUNNING);
        waddr   = tgt_q;
        wdata   = SLOT_RUNNABLE;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) begin
          we                = 1'b1;
          waddr             = chk_addr_q;
          wdata             = is_alloc_q ? SLOT_READY : SLOT_RUNNING;
          res_d.status      = STATUS_OK;
          res_d.chosen_slot = chk_w[5:0];
          res_d.first_run   = !is_alloc_q && (sdata == SLOT_READY);
          state_d           = ST_DONE;
        end else if (!chk_pend_q && cnt_q == CW'(SLOTS)) begin
          res_d.status = is_alloc_q ? STATUS_FULL : STATUS_IDLE;
          state_d      = ST_DONE;
        end else if (cnt_q != CW'(SLOTS)) begin
          chk_pend_d = 1'b1;
          chk_addr_d = rd_addr_q;
          cnt_d      = cnt_q + 1'b1;
          rd_addr_d  = (rd_addr_q == IW'(SLOTS - 1)) ? '0 : rd_addr_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    vld_d = vld_q;
    if (we) begin
      vld_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chk_pend_q  <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_pend_q  <= chk_pend_d;
      vld_q       <= vld_d;
      rd_vld_q    <= vld_q[raddr];
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_alloc_q <= is_alloc_d;
    tgt_q      <= tgt_d;
    rd_addr_q  <= rd_addr_d;
    cnt_q      <= cnt_d;
    chk_addr_q <= chk_addr_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for task_slot_round_robin_dispatcher_unit.
// Drives allocate, release and switch items and checks each result against a slot-table predictor.
// Depends on tsrr_pkg and the dispatcher RTL.
`timescale 1ns / 1ps

module testbench;
  import tsrr_pkg::*;

  localparam int SLOTS = 64;
  localparam int N_RANDOM = 1400;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  class dispatch_scoreboard;
    logic [1:0] slot_table [SLOTS];
    rsp_t       expected_rsp [$];
    int         fails;
    int         running_slot;

    function new();
      foreach (slot_table[i]) slot_table[i] = SLOT_UNUSED;
      fails = 0;
      running_slot = -1;
    endfunction

    function void note_request(req_t req);
      rsp_t want;
      int   idx;
      int   start;
      want = '0;
      case (req.op)
        OP_ALLOC: begin
          want.status = STATUS_FULL;
          for (idx = 0; idx < SLOTS; idx++) begin
            if (slot_table[idx] == SLOT_UNUSED) begin
              slot_table[idx] = SLOT_READY;
              want.status = STATUS_OK;
              want.chosen_slot = idx[5:0];
              break;
            end
          end
        end
        OP_RELEASE: begin
          if (int'(req.target_slot) < SLOTS) begin
            slot_table[req.target_slot] = SLOT_UNUSED;
            if (running_slot == int'(req.target_slot)) running_slot = -1;
          end
        end
        OP_SWITCH: begin
          start = 0;
          if (req.preempt && int'(req.target_slot) < SLOTS) begin
            if (slot_table[req.target_slot] == SLOT_RUNNING)
              slot_table[req.target_slot] = SLOT_RUNNABLE;
            start = (int'(req.target_slot) + 1) % SLOTS;
          end
          want.status = STATUS_IDLE;
          for (int n = 0; n < SLOTS; n++) begin
            idx = (start + n) % SLOTS;
            if (slot_table[idx] == SLOT_READY || slot_table[idx] == SLOT_RUNNABLE) begin
              want.status = STATUS_OK;
              want.chosen_slot = idx[5:0];
              want.first_run = (slot_table[idx] == SLOT_READY);
              slot_table[idx] = SLOT_RUNNING;
              running_slot = idx;
              break;
            end
          end
        end
        default: ;
      endcase
      expected_rsp.push_back(want);
    endfunction

    function void note_fail(string msg);
      fails++;
      $error("%s", msg);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got)
        note_fail($sformatf("%s: expected %0d, got %0d", name, want, got));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        note_fail("result item with nothing expected");
        return;
      end
      want = expected_rsp.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("chosen_slot", want.chosen_slot, got.chosen_slot);
      compare_field("first_run", want.first_run, got.first_run);
    endfunction

    function int used_count();
      used_count = 0;
      foreach (slot_table[i]) if (slot_table[i] != SLOT_UNUSED) used_count++;
    endfunction

    function int pick_used_slot();
      int used [$];
      foreach (slot_table[i]) if (slot_table[i] != SLOT_UNUSED) used.push_back(i);
      if (used.size() == 0) return $urandom_range(0, SLOTS - 1);
      return used[$urandom_range(0, used.size() - 1)];
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  req_t in_item = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  rsp_t out_item;

  dispatch_scoreboard board;
  bit  calm = 1'b0;
  int  stall_left = 0;
  int  sent = 0;

  task_slot_round_robin_dispatcher_unit #(.SLOTS(SLOTS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic req_t mk_req(logic [1:0] op, int target, bit preempt);
    req_t req;
    req.op = op;
    req.target_slot = target[5:0];
    req.preempt = preempt;
    return req;
  endfunction

  task automatic send_req(req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(req);
    sent++;
  endtask

  // result side: check accepted items, then choose the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) board.check_response(out_item);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic run_directed();
    send_req(mk_req(OP_SWITCH, 0, 1'b0));
    send_req(mk_req(OP_SWITCH, 63, 1'b1));
    send_req(mk_req(OP_RELEASE, 5, 1'b0));
    send_req(mk_req(OP_UNKNOWN, 63, 1'b1));
    repeat (4) send_req(mk_req(OP_ALLOC, 0, 1'b0));
    send_req(mk_req(OP_SWITCH, 42, 1'b0));
    send_req(mk_req(OP_SWITCH, 0, 1'b1));
    send_req(mk_req(OP_SWITCH, 1, 1'b1));
    send_req(mk_req(OP_SWITCH, 2, 1'b1));
    // wraps past the top of the table back to the runnable slot 0
    send_req(mk_req(OP_SWITCH, 3, 1'b1));
    // preempting an unused slot only moves the scan start
    send_req(mk_req(OP_SWITCH, 10, 1'b1));
    send_req(mk_req(OP_RELEASE, 2, 1'b0));
    send_req(mk_req(OP_ALLOC, 63, 1'b1));
    send_req(mk_req(OP_SWITCH, 63, 1'b1));
    for (int s = 0; s < 4; s++) send_req(mk_req(OP_RELEASE, s, 1'b0));
    send_req(mk_req(OP_ALLOC, 0, 1'b0));
    send_req(mk_req(OP_SWITCH, 0, 1'b0));
    // lone running task set aside is picked again
    send_req(mk_req(OP_SWITCH, 0, 1'b1));
    send_req(mk_req(OP_RELEASE, 0, 1'b0));
    send_req(mk_req(OP_SWITCH, 0, 1'b1));
  endtask

  task automatic send_random_item();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      send_req(mk_req(OP_ALLOC, $urandom_range(0, SLOTS - 1), 1'($urandom_range(0, 1))));
    end else if (roll < 55) begin
      if ($urandom_range(0, 9) < 7)
        send_req(mk_req(OP_RELEASE, board.pick_used_slot(), 1'($urandom_range(0, 1))));
      else
        send_req(mk_req(OP_RELEASE, $urandom_range(0, SLOTS - 1), 1'($urandom_range(0, 1))));
    end else if (roll < 95) begin
      if (board.running_slot >= 0 && $urandom_range(0, 9) < 8)
        send_req(mk_req(OP_SWITCH, board.running_slot, 1'b1));
      else
        send_req(mk_req(OP_SWITCH, $urandom_range(0, SLOTS - 1), 1'($urandom_range(0, 1))));
    end else begin
      send_req(mk_req(OP_UNKNOWN, $urandom_range(0, SLOTS - 1), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_random();
    int roll;
    int count;
    int last_mode_change;
    last_mode_change = 0;
    // start with the table filled to overflow
    repeat (SLOTS + 2) send_req(mk_req(OP_ALLOC, 0, 1'b0));
    while (sent < N_RANDOM) begin
      if (sent - last_mode_change >= 64) begin
        calm = ($urandom_range(0, 4) == 0);
        last_mode_change = sent;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        count = SLOTS - board.used_count() + $urandom_range(1, 3);
        repeat (count) send_req(mk_req(OP_ALLOC, $urandom_range(0, SLOTS - 1), 1'b0));
      end else if (roll < 7) begin
        count = $urandom_range(8, 40);
        repeat (count) send_req(mk_req(OP_RELEASE, board.pick_used_slot(), 1'b0));
      end else begin
        send_random_item();
      end
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    calm = 1'b1;
    while (board.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
    if (board.fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
